// ===== rtl/bsgtc_pkg.sv =====
// Shared types, widths, register indexes and reset values of the global tick counter.
package bsgtc_pkg;

	// Field and register widths
	localparam int CPU_ID_W  = 8;
	localparam int MAP_W     = 64;
	localparam int COUNT_W   = 4;
	localparam int STEP_W    = 32;
	localparam int CNT_W     = 64;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 64;

	// Slot count the map can describe
	localparam int DEF_MAX_SLOTS = MAP_W / CPU_ID_W;

	// Register reset values
	localparam logic [MAP_W-1:0]   CORE_MAP_RST   = 64'h0000_0000_0302_0100;
	localparam logic [COUNT_W-1:0] CORE_COUNT_RST = 4'd4;
	localparam logic [STEP_W-1:0]  STEP_RST       = 32'd250;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CORE_MAP   = 2'd0,
		REG_CORE_COUNT = 2'd1,
		REG_STEP       = 2'd2
	} reg_idx_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_UNKNOWN = 2'd0,
		ST_SKIP    = 2'd1,
		ST_ARRIVE  = 2'd2,
		ST_DONE    = 2'd3
	} status_t;

	// Decision handed from the slot matcher to the state logic
	typedef struct packed {
		status_t status;
		logic    upd;    // arrival marks take the new value
		logic    close;  // round completes with this tick
	} decision_t;

endpackage

// ===== rtl/bsgtc_match.sv =====
// Slot lookup and round decision for one tick against the current arrival marks.
module bsgtc_match #(
	parameter int MAX_SLOTS = bsgtc_pkg::DEF_MAX_SLOTS
) (
	input  logic [bsgtc_pkg::CPU_ID_W-1:0] cpu_id,
	input  logic [bsgtc_pkg::MAP_W-1:0]    core_map,
	input  logic [bsgtc_pkg::COUNT_W-1:0]  core_count,
	input  logic [MAX_SLOTS-1:0]           marks,
	output bsgtc_pkg::decision_t           dec,
	output logic [MAX_SLOTS-1:0]           next_marks
);

	logic [bsgtc_pkg::COUNT_W-1:0] n_used;
	logic [MAX_SLOTS-1:0]          used;
	logic [MAX_SLOTS-1:0]          hit;
	logic [MAX_SLOTS-1:0]          merged;
	logic                          found;
	logic                          already;
	logic                          close;

	// Clamp the slot count to the slots this build holds
	assign n_used = (core_count > bsgtc_pkg::COUNT_W'(MAX_SLOTS)) ?
		bsgtc_pkg::COUNT_W'(MAX_SLOTS) : core_count;

	// Compare every slot in use, keep only the lowest match
	always_comb begin
		logic seen;
		seen = 1'b0;
		for (int i = 0; i < MAX_SLOTS; i++) begin
			used[i] = bsgtc_pkg::COUNT_W'(i) < n_used;
			hit[i]  = 1'b0;
			if (used[i] && !seen &&
			    core_map[i*bsgtc_pkg::CPU_ID_W +: bsgtc_pkg::CPU_ID_W] == cpu_id) begin
				hit[i] = 1'b1;
				seen   = 1'b1;
			end
		end
	end

	assign found   = |hit;
	assign already = |(hit & marks);
	assign merged  = marks | hit;
	assign close   = (merged & used) == used;

	// Pick status and next marks
	always_comb begin
		dec.upd    = 1'b0;
		dec.close  = 1'b0;
		next_marks = merged;
		if (!found) begin
			dec.status = bsgtc_pkg::ST_UNKNOWN;
		end else if (already) begin
			dec.status = bsgtc_pkg::ST_SKIP;
		end else if (close) begin
			dec.status = bsgtc_pkg::ST_DONE;
			dec.upd    = 1'b1;
			dec.close  = 1'b1;
			next_marks = '0;
		end else begin
			dec.status = bsgtc_pkg::ST_ARRIVE;
			dec.upd    = 1'b1;
		end
	end

endmodule

// ===== rtl/barrier_synced_global_tick_counter_core.sv =====
// Top level of the lockstep global tick counter: config, state and result register.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  cfg     | in        | cfg_we             | cfg_index, cfg_wdata
//  in      | in        | in_valid, in_stall | cpu_id
//  out     | out       | out_valid, out_stall | status, round_done, global_count
//
// One tick beat per cycle sustained while out is not stalled; a beat goes through the
// input register, then the result register, with the single lookup-and-add pass between.
// Reset clears arrival marks, both counters and loads the register reset values.
// A stalled result holds in the output register; the input register still takes
// a beat, and in_stall rises only when both registers are full and out is stalled.
module barrier_synced_global_tick_counter_core #(
	parameter int MAX_SLOTS = bsgtc_pkg::DEF_MAX_SLOTS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [bsgtc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bsgtc_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [bsgtc_pkg::CPU_ID_W-1:0]   cpu_id,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [1:0]                       status,
	output logic [bsgtc_pkg::CNT_W-1:0]      round_done,
	output logic [bsgtc_pkg::CNT_W-1:0]      global_count
);

	logic [bsgtc_pkg::MAP_W-1:0]    core_map_q;
	logic [bsgtc_pkg::COUNT_W-1:0]  core_count_q;
	logic [bsgtc_pkg::STEP_W-1:0]   step_q;

	logic                           valid_s1;
	logic [bsgtc_pkg::CPU_ID_W-1:0] cpu_id_s1;

	logic [MAX_SLOTS-1:0]           marks_q;
	logic [bsgtc_pkg::CNT_W-1:0]    rounds_q;
	logic [bsgtc_pkg::CNT_W-1:0]    global_q;

	logic                           out_valid_q;
	bsgtc_pkg::status_t             status_q;
	logic [bsgtc_pkg::CNT_W-1:0]    round_out_q;
	logic [bsgtc_pkg::CNT_W-1:0]    global_out_q;

	bsgtc_pkg::decision_t           dec;
	logic [MAX_SLOTS-1:0]           next_marks;
	logic                           out_free;
	logic                           take;
	logic [bsgtc_pkg::CNT_W-1:0]    rounds_nx;
	logic [bsgtc_pkg::CNT_W-1:0]    global_nx;

	// Handshake: the result register frees when empty or being drained
	assign out_free  = !out_valid_q || !out_stall;
	assign take      = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core_map_q   <= bsgtc_pkg::CORE_MAP_RST;
			core_count_q <= bsgtc_pkg::CORE_COUNT_RST;
			step_q       <= bsgtc_pkg::STEP_RST;
		end else if (cfg_we) begin
			case (bsgtc_pkg::reg_idx_t'(cfg_index))
				bsgtc_pkg::REG_CORE_MAP:   core_map_q   <= cfg_wdata;
				bsgtc_pkg::REG_CORE_COUNT: core_count_q <= cfg_wdata[bsgtc_pkg::COUNT_W-1:0];
				bsgtc_pkg::REG_STEP:       step_q       <= cfg_wdata[bsgtc_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register: take a beat whenever it is empty or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cpu_id_s1 <= cpu_id;
		end
	end

	// Lookup and round decision
	bsgtc_match #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_match (
		.cpu_id     (cpu_id_s1),
		.core_map   (core_map_q),
		.core_count (core_count_q),
		.marks      (marks_q),
		.dec        (dec),
		.next_marks (next_marks)
	);

	// Advance counters on a closing tick
	assign rounds_nx = dec.close ? rounds_q + bsgtc_pkg::CNT_W'(1) : rounds_q;
	assign global_nx = dec.close ?
		global_q + bsgtc_pkg::CNT_W'(step_q) : global_q;

	// Round state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marks_q  <= '0;
			rounds_q <= '0;
			global_q <= '0;
		end else if (take) begin
			if (dec.upd) begin
				marks_q <= next_marks;
			end
			rounds_q <= rounds_nx;
			global_q <= global_nx;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			status_q     <= dec.status;
			round_out_q  <= rounds_nx;
			global_out_q <= global_nx;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign round_done   = round_out_q;
	assign global_count = global_out_q;

	// Closing a round clears every arrival mark
	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && dec.close) |=> (marks_q == '0))
		else $error("arrival marks not cleared after round close");

	// Round count only ever steps by one
	a_round_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(rounds_q) |-> (rounds_q == $past(rounds_q) + bsgtc_pkg::CNT_W'(1)))
		else $error("round count moved by other than one");

	// Global counter advances by the step on a close
	a_global_step: assert property (@(posedge clk) disable iff (!arst_n)
		(take && dec.close) |=>
		(global_q == $past(global_q) + bsgtc_pkg::CNT_W'($past(step_q))))
		else $error("global counter did not advance by the step amount");

	// Unknown or skipped ticks leave the round untouched
	a_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		(take && (dec.status == bsgtc_pkg::ST_UNKNOWN || dec.status == bsgtc_pkg::ST_SKIP))
		|=> ($stable(marks_q) && $stable(rounds_q) && $stable(global_q)))
		else $error("state changed on an unknown or skipped tick");

endmodule
